// ===== rtl/core/bpac_pkg.sv =====
// Shared types, codes and constants for the budget proposal admission check.
`timescale 1ns / 1ps

package bpac_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int NUM_CPUS_DEF    = 8;

    localparam int BUDGET_W = 20;
    localparam int VM_W     = 6;
    localparam int CPU_W    = 3;
    localparam int TICK_W   = 64;
    localparam int MASK_W   = 64;
    localparam int UTIL_W   = 32;
    localparam int MINT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int PPM_FULL   = 1000000;
    localparam int PROD_W     = 2 * BUDGET_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BUDGET = 3'd0,
        CFG_MIN_BUDGET  = 3'd1,
        CFG_MAX_BUDGET  = 3'd2,
        CFG_MAX_STEP    = 3'd3,
        CFG_PERIOD      = 3'd4,
        CFG_ACTIVE_MASK = 3'd5,
        CFG_MIN_TICKS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                start;
        logic [BUDGET_W-1:0] budget;
        logic [BUDGET_W-1:0] period;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/bpac_div.sv =====
// Utilization unit: budget times one million, then a radix-2 restoring divide by the period.
`timescale 1ns / 1ps

module bpac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpac_pkg::t_div_req i_req,
    output bpac_pkg::t_div_rsp o_rsp
);

    logic                              r_mul;
    logic                              r_run;
    logic                              r_done;
    logic [bpac_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [bpac_pkg::PROD_W-1:0]       r_prod;
    logic [bpac_pkg::PROD_W-1:0]       r_quo;
    logic [bpac_pkg::BUDGET_W-1:0]     r_rem;
    logic [bpac_pkg::BUDGET_W-1:0]     r_div;

    logic [bpac_pkg::BUDGET_W:0]       w_trial;
    logic [bpac_pkg::BUDGET_W:0]       w_diff;
    logic                              w_qbit;
    logic [bpac_pkg::BUDGET_W-1:0]     w_ppm;

    assign w_ppm   = bpac_pkg::BUDGET_W'(bpac_pkg::PPM_FULL);
    assign w_trial = {r_rem, r_quo[bpac_pkg::PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    // Control: the product is registered and loaded, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_mul <= 1'b1;
            end else if (r_mul) begin
                r_mul <= 1'b0;
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bpac_pkg::DIV_CNT_W'(bpac_pkg::DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= {{bpac_pkg::BUDGET_W{1'b0}}, i_req.budget} *
                      {{bpac_pkg::BUDGET_W{1'b0}}, w_ppm};
            r_div  <= i_req.period;
        end else if (r_mul) begin
            r_quo <= r_prod;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= {r_quo[bpac_pkg::PROD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[bpac_pkg::BUDGET_W-1:0] : w_trial[bpac_pkg::BUDGET_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/bpac_tick_store.sv =====
// Per-CPU store of the last accepted tick, with valid bits so reset reads as zero.
`timescale 1ns / 1ps

module bpac_tick_store #(
    parameter int NUM_CPUS = bpac_pkg::NUM_CPUS_DEF,
    parameter int IDX_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [IDX_W-1:0]            i_rd_idx,
    output logic [bpac_pkg::TICK_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [IDX_W-1:0]            i_wr_idx,
    input  logic [bpac_pkg::TICK_W-1:0] i_wr_data
);

    logic [bpac_pkg::TICK_W-1:0] r_mem [NUM_CPUS];
    logic [NUM_CPUS-1:0]         r_vld;
    logic [bpac_pkg::TICK_W-1:0] r_rd_data;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/core/budget_proposal_admission_check.sv =====
// Top level of the budget proposal admission check: sequencer, checks and result register.
`timescale 1ns / 1ps

// Checks a proposal of per-VM CPU budgets, one entry word per handshake, the
// final entry flagged by i_last_entry; every entry returns one result word.
// Entries are taken one at a time: o_stall is low only while the sequencer is
// idle. An entry that passes the per-entry checks goes from accept to result
// through a register step, a check step, a multiply step, the radix-2
// restoring divider (one quotient bit per cycle) and the accumulate and
// finish states. An entry that fails a check, or that follows an earlier
// error, skips the divider. A result word held on a stalled output does not
// block the next entry until that entry's result is ready. The per-CPU tick
// store clears at reset through valid bits, so no clearing pass is needed.
// Configuration writes are accepted whenever i_cfg_we is high and should only
// be issued between entries.
module budget_proposal_admission_check #(
    parameter int MAX_ENTRIES = bpac_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_CPUS    = bpac_pkg::NUM_CPUS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // entry channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bpac_pkg::VM_W-1:0]       i_vm_index,
    input  logic [bpac_pkg::BUDGET_W-1:0]   i_new_budget,
    input  logic [bpac_pkg::BUDGET_W-1:0]   i_current_budget,
    input  logic                            i_reserved_set,
    input  logic                            i_sequence_given,
    input  logic [bpac_pkg::CPU_W-1:0]      i_cpu_index,
    input  logic [bpac_pkg::TICK_W-1:0]     i_now_tick,
    input  logic                            i_last_entry,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic                            o_done_res,
    output logic [bpac_pkg::UTIL_W-1:0]     o_utilization_ppm,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [bpac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TOTAL_W = $clog2(MAX_ENTRIES + 2);
    localparam int CIDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CEXT_W  = 7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_ACC   = 5'b01000,
        S_FINAL = 5'b10000
    } t_state;

    // Configuration registers
    logic [bpac_pkg::BUDGET_W-1:0] r_pool_budget;
    logic [bpac_pkg::BUDGET_W-1:0] r_min_budget;
    logic [bpac_pkg::BUDGET_W-1:0] r_max_budget;
    logic [bpac_pkg::BUDGET_W-1:0] r_max_step;
    logic [bpac_pkg::BUDGET_W-1:0] r_period;
    logic [bpac_pkg::MASK_W-1:0]   r_mask;
    logic [bpac_pkg::MINT_W-1:0]   r_min_ticks;

    // Latched entry word
    logic [bpac_pkg::VM_W-1:0]     r_vm;
    logic [bpac_pkg::BUDGET_W-1:0] r_nb;
    logic [bpac_pkg::BUDGET_W-1:0] r_cur;
    logic                          r_rsvd;
    logic                          r_seq;
    logic [bpac_pkg::CPU_W-1:0]    r_cpu;
    logic [bpac_pkg::TICK_W-1:0]   r_now;
    logic                          r_last;

    // Proposal state
    t_state                        r_state;
    bpac_pkg::t_status             r_sticky;
    logic [bpac_pkg::UTIL_W-1:0]   r_util_sum;
    logic [bpac_pkg::MASK_W-1:0]   r_seen;
    logic [TOTAL_W-1:0]            r_total;

    // Result register
    logic                          r_out_valid;
    bpac_pkg::t_status             r_out_status;
    logic                          r_out_done;
    logic [bpac_pkg::UTIL_W-1:0]   r_out_util;

    bpac_pkg::t_div_req            w_div_req;
    bpac_pkg::t_div_rsp            w_div_rsp;

    logic [TOTAL_W-1:0]            w_total_nx;
    logic [bpac_pkg::BUDGET_W-1:0] w_cur_eff;
    logic [bpac_pkg::BUDGET_W-1:0] w_delta;
    logic                          w_entry_bad;
    logic [bpac_pkg::PROD_W:0]     w_sum;
    logic [CEXT_W-1:0]             w_cpu_ext;
    logic [CIDX_W-1:0]             w_cpu_idx;
    logic                          w_cpu_ok;
    logic [bpac_pkg::TICK_W-1:0]   w_prev_tick;
    logic [bpac_pkg::TICK_W-1:0]   w_elapsed;
    logic                          w_too_soon;
    bpac_pkg::t_status             w_final;
    logic                          w_tick_wr;
    logic                          w_out_free;

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_budget <= '0;
            r_min_budget  <= '0;
            r_max_budget  <= '1;
            r_max_step    <= '0;
            r_period      <= bpac_pkg::BUDGET_W'(1);
            r_mask        <= '0;
            r_min_ticks   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpac_pkg::CFG_POOL_BUDGET: r_pool_budget <= i_cfg_data[bpac_pkg::BUDGET_W-1:0];
                bpac_pkg::CFG_MIN_BUDGET:  r_min_budget  <= i_cfg_data[bpac_pkg::BUDGET_W-1:0];
                bpac_pkg::CFG_MAX_BUDGET:  r_max_budget  <= i_cfg_data[bpac_pkg::BUDGET_W-1:0];
                bpac_pkg::CFG_MAX_STEP:    r_max_step    <= i_cfg_data[bpac_pkg::BUDGET_W-1:0];
                bpac_pkg::CFG_PERIOD:      r_period      <= i_cfg_data[bpac_pkg::BUDGET_W-1:0];
                bpac_pkg::CFG_ACTIVE_MASK: r_mask        <= i_cfg_data[bpac_pkg::MASK_W-1:0];
                bpac_pkg::CFG_MIN_TICKS:   r_min_ticks   <= i_cfg_data[bpac_pkg::MINT_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-entry checks, evaluated in S_CHECK on the latched word
    assign w_total_nx = (r_total <= TOTAL_W'(MAX_ENTRIES)) ? r_total + 1'b1 : r_total;
    assign w_cur_eff  = (r_cur == '0) ? r_pool_budget : r_cur;
    assign w_delta    = (r_nb > w_cur_eff) ? r_nb - w_cur_eff : w_cur_eff - r_nb;
    assign w_entry_bad = r_rsvd || !r_mask[r_vm] || r_seen[r_vm] ||
                         (r_nb < r_min_budget) || (r_nb > r_max_budget) ||
                         (w_delta > r_max_step);

    // Accumulated utilization with the new quotient
    assign w_sum = (bpac_pkg::PROD_W + 1)'(r_util_sum) +
                   (bpac_pkg::PROD_W + 1)'(w_div_rsp.quotient);

    // Final checks for the last entry
    assign w_cpu_ext   = CEXT_W'(r_cpu);
    assign w_cpu_idx   = w_cpu_ext[CIDX_W-1:0];
    assign w_cpu_ok    = (w_cpu_ext < CEXT_W'(NUM_CPUS));
    assign w_elapsed   = r_now - w_prev_tick;
    assign w_too_soon  = (w_prev_tick != '0) &&
                         (w_elapsed < bpac_pkg::TICK_W'(r_min_ticks));

    always_comb begin
        w_final   = r_sticky;
        w_tick_wr = 1'b0;
        if (r_last) begin
            if (!r_seq || !w_cpu_ok) begin
                w_final = bpac_pkg::ST_INVALID;
            end else if (r_sticky == bpac_pkg::ST_OK && r_seen != r_mask) begin
                w_final = bpac_pkg::ST_INVALID;
            end else if (r_sticky == bpac_pkg::ST_OK) begin
                if (w_too_soon) begin
                    w_final = bpac_pkg::ST_BUSY;
                end else begin
                    w_tick_wr = 1'b1;
                end
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;

    assign w_div_req.start  = (r_state == S_CHECK) && (w_total_nx <= TOTAL_W'(MAX_ENTRIES)) &&
                              (r_period != '0) && (r_sticky == bpac_pkg::ST_OK) &&
                              !w_entry_bad;
    assign w_div_req.budget = r_nb;
    assign w_div_req.period = r_period;

    // Sequencer and proposal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sticky   <= bpac_pkg::ST_OK;
            r_util_sum <= '0;
            r_seen     <= '0;
            r_total    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_total <= w_total_nx;
                    if (w_total_nx > TOTAL_W'(MAX_ENTRIES) || r_period == '0) begin
                        r_sticky <= bpac_pkg::ST_INVALID;
                        r_state  <= S_FINAL;
                    end else if (r_sticky != bpac_pkg::ST_OK) begin
                        r_state <= S_FINAL;
                    end else if (w_entry_bad) begin
                        r_sticky <= bpac_pkg::ST_INVALID;
                        r_state  <= S_FINAL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_sum > (bpac_pkg::PROD_W + 1)'(bpac_pkg::PPM_FULL)) begin
                        r_sticky   <= bpac_pkg::ST_BUSY;
                        // saturate at the top of the 32-bit field
                        r_util_sum <= (w_sum[bpac_pkg::PROD_W:bpac_pkg::UTIL_W] != '0) ?
                                      '1 : w_sum[bpac_pkg::UTIL_W-1:0];
                    end else begin
                        r_util_sum     <= w_sum[bpac_pkg::UTIL_W-1:0];
                        r_seen[r_vm]   <= 1'b1;
                    end
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    // hold until the result register can take the word
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (r_last) begin
                            r_sticky   <= bpac_pkg::ST_OK;
                            r_util_sum <= '0;
                            r_seen     <= '0;
                            r_total    <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Latch the entry word on accept
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_vm   <= i_vm_index;
            r_nb   <= i_new_budget;
            r_cur  <= i_current_budget;
            r_rsvd <= i_reserved_set;
            r_seq  <= i_sequence_given;
            r_cpu  <= i_cpu_index;
            r_now  <= i_now_tick;
            r_last <= i_last_entry;
        end
    end

    // Result register: load in S_FINAL, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINAL && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL && w_out_free) begin
            r_out_status <= w_final;
            r_out_done   <= r_last;
            r_out_util   <= r_util_sum;
        end
    end

    bpac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // The read address follows the latched CPU, so the stored tick is ready
    // by S_FINAL.
    bpac_tick_store #(
        .NUM_CPUS (NUM_CPUS),
        .IDX_W    (CIDX_W)
    ) u_tick_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (w_cpu_idx),
        .o_rd_data (w_prev_tick),
        .i_wr_en   (r_state == S_FINAL && w_out_free && w_tick_wr),
        .i_wr_idx  (w_cpu_idx),
        .i_wr_data (r_now)
    );

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_done_res        = r_out_done;
    assign o_utilization_ppm = r_out_util;

    a_util_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sticky == bpac_pkg::ST_OK) |-> (r_util_sum <= bpac_pkg::UTIL_W'(bpac_pkg::PPM_FULL)))
        else $error("utilization above full while proposal is ok");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_W'(MAX_ENTRIES + 1))
        else $error("entry count past saturation");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_CHECK))
        else $error("accepted word did not enter the check state");

endmodule
